### sv/mrd_pkg.sv
// Shared types, constants and length decode for the Modbus RTU response deframer.
package mrd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 256;
    localparam int MIN_FRAME_BYTES     = 5;

    localparam logic [8:0]  MAX_FRAME_RST = 9'd256;
    localparam logic [15:0] TIMEOUT_RST   = 16'd1000;

    // APB word addresses (bit 2 of paddr selects the register)
    localparam logic REG_MAX_FRAME = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    localparam logic [7:0] FC_EXC_MASK   = 8'h80;
    localparam logic [7:0] FC_READ_COILS = 8'h01;
    localparam logic [7:0] FC_READ_DISC  = 8'h02;
    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] FC_WR_COIL    = 8'h05;
    localparam logic [7:0] FC_WR_REG     = 8'h06;
    localparam logic [7:0] FC_WR_COILS   = 8'h0F;
    localparam logic [7:0] FC_WR_REGS    = 8'h10;

    localparam logic [8:0] LEN_EXCEPTION = 9'd5;
    localparam logic [8:0] LEN_WRITE     = 9'd8;
    localparam logic [8:0] LEN_READ_HDR  = 9'd3;
    localparam logic [8:0] LEN_CRC       = 9'd2;
    localparam logic [8:0] POS_FUNC      = 9'd2;
    localparam logic [8:0] POS_COUNT     = 9'd3;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_RECV     = 3'd1,
        ST_DONE     = 3'd2,
        ST_TIMEOUT  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_TOOLARGE = 3'd5
    } status_t;

    // first member sits in the top bits; status lands in bits [2:0]
    typedef struct packed {
        logic       pad;
        logic       partial;
        logic [8:0] expected_length;
        logic [8:0] received_length;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       byte_valid;
        status_t    status;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    typedef struct packed {
        logic [8:0]  max_frame_bytes;
        logic [15:0] timeout_ticks;
    } cfg_t;

    // length once nb bytes are held; fc is the function code, rx the latest byte
    function automatic logic [8:0] decode_length(input logic [8:0] nb,
                                                 input logic [7:0] fc,
                                                 input logic [7:0] rx);
        logic [8:0] len;
        len = '0;
        if (nb >= POS_FUNC) begin
            if ((fc & FC_EXC_MASK) != 8'h00) begin
                len = LEN_EXCEPTION;
            end
            else begin
                case (fc) inside
                    FC_READ_COILS, FC_READ_DISC, FC_READ_HOLD, FC_READ_INPUT:
                    begin
                        if (nb == POS_COUNT) begin
                            len = LEN_READ_HDR + {1'b0, rx} + LEN_CRC;
                        end
                    end
                    FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS:
                    begin
                        len = LEN_WRITE;
                    end
                    default:
                    begin
                        len = '0;
                    end
                endcase
            end
        end
        return len;
    endfunction

endpackage

### sv/modbus_rtu_response_deframer_top.sv
// Top level of the Modbus RTU response deframer.
//
// Input stream: s_tuser carries the item kind (start, byte, tick), s_tdata the
// received byte. Every accepted item yields exactly one result on the output
// stream, with status, the stored byte and its index, the lengths so far and
// the partial-timeout flag packed into m_tdata.
// Each result is registered in the output register, or in the skid stage while
// the output stalls. Throughput: one item per cycle while s_tready is high; the
// frame state updates per accepted item, so item n+1 can follow item n directly.
// If the receiver stalls, one further item is held in a skid stage; s_tready
// drops only while that stage is full and rises again once the output moves.
// Reset clears the frame state (idle, no bytes, length unknown), empties the
// result path and loads the defaults: frame limit 256, timeout 1000 ticks.
// The APB port writes the frame limit at 0x0 and the timeout at 0x4; a write
// must not overlap an item in flight.
module modbus_rtu_response_deframer_top #(
    parameter int MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic [1:0]                   s_tuser,   // [1:0] mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] status, [3] byte_valid, [11:4] byte_index, [19:12] byte_value,
    // [28:20] received_length, [37:29] expected_length, [38] partial, [39] zero
    output logic [mrd_pkg::RESULT_W-1:0] m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    mrd_pkg::cfg_t    cfg;
    mrd_pkg::result_t core_res;
    mrd_pkg::result_t m_res;
    logic             in_fire;

    assign pready  = 1'b1;
    assign in_fire = s_tvalid && s_tready;

    mrd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mrd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .mode    (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg),
        .result  (core_res)
    );

    mrd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_res)
    );

    assign m_tdata = m_res;

`ifndef NO_ASSERTIONS
    // input only blocks when the result path was stalled with a result waiting
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("s_tready low without a stalled result");

    a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.status == mrd_pkg::ST_DONE)
            |-> (m_res.received_length == m_res.expected_length))
        else $error("complete frame with mismatching length");

    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.byte_valid)
            |-> (m_res.status == mrd_pkg::ST_RECV || m_res.status == mrd_pkg::ST_DONE
                 || m_res.status == mrd_pkg::ST_TOOLARGE))
        else $error("stored byte reported with a non-receiving status");

    a_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res.partial) |-> (m_res.status == mrd_pkg::ST_TIMEOUT))
        else $error("partial flag outside a timeout");
`endif

endmodule

### sv/mrd_cfg.sv
// APB configuration registers: frame limit and timeout.
module mrd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output mrd_pkg::cfg_t       cfg
);

    logic [8:0]  max_frame_reg;
    logic [15:0] timeout_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= mrd_pkg::MAX_FRAME_RST;
            timeout_reg   <= mrd_pkg::TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == mrd_pkg::REG_MAX_FRAME)
            begin
                max_frame_reg <= pwdata[8:0];
            end
            else
            begin
                timeout_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == mrd_pkg::REG_TIMEOUT)
        begin
            prdata = {16'h0000, timeout_reg};
        end
        else
        begin
            prdata = {23'h0, max_frame_reg};
        end
    end

    assign cfg.max_frame_bytes = max_frame_reg;
    assign cfg.timeout_ticks   = timeout_reg;

endmodule

### sv/mrd_core.sv
// Frame state and per-item update: byte counting, length decode, timeout.
module mrd_core #(
    parameter int MAX_FRAME_BYTES = mrd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [1:0]          mode,
    input  logic [7:0]          rx_byte,
    input  mrd_pkg::cfg_t       cfg,
    output mrd_pkg::result_t    result
);

    // the 9-bit limit register caps the effective limit at 511
    localparam int LIM_MAX = (MAX_FRAME_BYTES < 511) ? MAX_FRAME_BYTES : 511;
    localparam int CNT_W   = $clog2(LIM_MAX + 1);

    logic             active_reg,   active_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [8:0]       expected_reg, expected_next;
    logic [7:0]       func_reg,     func_next;
    logic [15:0]      elapsed_reg,  elapsed_next;

    logic [8:0]       lim9;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] nb;
    logic [8:0]       nb9;

    always_comb
    begin
        if (cfg.max_frame_bytes < 9'(mrd_pkg::MIN_FRAME_BYTES))
        begin
            lim9 = 9'(mrd_pkg::MIN_FRAME_BYTES);
        end
        else if (cfg.max_frame_bytes > 9'(LIM_MAX))
        begin
            lim9 = 9'(LIM_MAX);
        end
        else
        begin
            lim9 = cfg.max_frame_bytes;
        end
    end

    assign lim = lim9[CNT_W-1:0];
    assign nb  = count_reg + CNT_W'(1);
    assign nb9 = 9'(nb);

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        expected_next = expected_reg;
        func_next     = func_reg;
        elapsed_next  = elapsed_reg;

        result            = '0;
        result.status     = active_reg ? mrd_pkg::ST_RECV : mrd_pkg::ST_IDLE;

        case (mrd_pkg::mode_t'(mode))
            mrd_pkg::MODE_START:
            begin
                active_next   = 1'b1;
                count_next    = '0;
                expected_next = '0;
                func_next     = '0;
                elapsed_next  = '0;
                result.status = mrd_pkg::ST_RECV;
                if (cfg.timeout_ticks == 16'h0000)
                begin
                    active_next   = 1'b0;
                    result.status = mrd_pkg::ST_TIMEOUT;
                end
            end
            mrd_pkg::MODE_BYTE:
            begin
                if (active_reg)
                begin
                    if (elapsed_reg >= cfg.timeout_ticks)
                    begin
                        active_next    = 1'b0;
                        result.status  = mrd_pkg::ST_TIMEOUT;
                        result.partial = (count_reg != '0);
                    end
                    else if (count_reg >= lim)
                    begin
                        active_next   = 1'b0;
                        result.status = mrd_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        result.byte_valid = 1'b1;
                        result.byte_index = 8'(count_reg);
                        result.byte_value = rx_byte;
                        count_next        = nb;
                        if (nb9 == mrd_pkg::POS_FUNC)
                        begin
                            func_next = rx_byte;
                        end
                        result.status = mrd_pkg::ST_RECV;
                        if (expected_reg == '0)
                        begin
                            expected_next = mrd_pkg::decode_length(nb9, func_next, rx_byte);
                            if (expected_next > lim9)
                            begin
                                active_next   = 1'b0;
                                result.status = mrd_pkg::ST_TOOLARGE;
                            end
                        end
                        if (active_next && (expected_next != '0) && (nb9 == expected_next))
                        begin
                            active_next   = 1'b0;
                            result.status = mrd_pkg::ST_DONE;
                        end
                    end
                end
            end
            mrd_pkg::MODE_TICK:
            begin
                if (active_reg)
                begin
                    if (elapsed_reg != 16'hFFFF)
                    begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                    if (elapsed_next >= cfg.timeout_ticks)
                    begin
                        active_next    = 1'b0;
                        result.status  = mrd_pkg::ST_TIMEOUT;
                        result.partial = (count_reg != '0);
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.received_length = 9'(count_next);
        result.expected_length = expected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            count_reg    <= '0;
            expected_reg <= '0;
            func_reg     <= '0;
            elapsed_reg  <= '0;
        end
        else if (in_fire)
        begin
            active_reg   <= active_next;
            count_reg    <= count_next;
            expected_reg <= expected_next;
            func_reg     <= func_next;
            elapsed_reg  <= elapsed_next;
        end
    end

endmodule

### sv/mrd_out_buf.sv
// Result register with skid stage; keeps the input open for one further result while the output stalls.
module mrd_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mrd_pkg::result_t      in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mrd_pkg::result_t      out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    mrd_pkg::result_t out_data_reg;
    mrd_pkg::result_t skid_data_reg;
    logic             in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
